>>> hw/rtl/motor_feedback_multiturn_decode_defines.svh
// Assertion macros shared by the decoder modules.
// Each macro needs clk; MFMD_ASSERT also rst_n.
`ifndef MOTOR_FEEDBACK_MULTITURN_DECODE_DEFINES_SVH
`define MOTOR_FEEDBACK_MULTITURN_DECODE_DEFINES_SVH
`ifndef SYNTHESIS
`define MFMD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MFMD_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MFMD_ASSERT(lbl, prop, msg)
`define MFMD_ASSERT_RST(lbl, prop, msg)
`endif
`endif

>>> hw/rtl/mfmd_pkg.sv
package mfmd_pkg;

  localparam int FRAME_ID_W  = 11;
  localparam int BYTE_W      = 8;
  localparam int ANGLE_W     = 16;
  localparam int WORD_W      = 16;
  localparam int TEMP_W      = 8;
  localparam int MOTOR_COUNT = 4;
  localparam int TURN_BITS   = 24;
  localparam int SLOT_W      = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;
  localparam int MOTOR_IDX_W = 2;
  localparam int TURN_OUT_W  = 24;
  localparam int Q10_W       = 43;
  localparam int DIST_W      = 24;
  localparam int DIST_OUT_W  = 48;

  // 8192 encoder counts per turn
  localparam int FRAC_BITS     = 13;
  localparam int Q10_PER_COUNT = 45;

  // turns * 8192 + angle, signed
  localparam int POS_W = TURN_BITS + FRAC_BITS + 1;
  localparam int LO_W  = POS_W / 2;
  localparam int HI_W  = POS_W - LO_W;
  localparam int Q10_EXT_W  = (POS_W + 7 > Q10_W) ? POS_W + 7 : Q10_W;
  localparam int DIST_EXT_W = (POS_W + DIST_W > FRAC_BITS + DIST_OUT_W) ?
                              POS_W + DIST_W : FRAC_BITS + DIST_OUT_W;

  localparam int JUMP_W = ANGLE_W + 1;
  localparam logic signed [JUMP_W-1:0] HALF_TURN     = JUMP_W'(4096);
  localparam logic signed [JUMP_W-1:0] NEG_HALF_TURN = JUMP_W'(-4096);
  localparam logic signed [TURN_BITS-1:0] TURN_MAX = {1'b0, {(TURN_BITS-1){1'b1}}};
  localparam logic signed [TURN_BITS-1:0] TURN_MIN = {1'b1, {(TURN_BITS-1){1'b0}}};

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_FRAME_ID = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIST_PER_TURN = 2'd1;
  localparam logic [FRAME_ID_W-1:0] BASE_ID_RESET    = 11'd513;

  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 176;

  typedef struct packed {
    logic [4:0]            pad;
    logic [BYTE_W-1:0]     temperature_byte;
    logic [BYTE_W-1:0]     current_low;
    logic [BYTE_W-1:0]     current_high;
    logic [BYTE_W-1:0]     speed_low;
    logic [BYTE_W-1:0]     speed_high;
    logic [BYTE_W-1:0]     angle_low;
    logic [BYTE_W-1:0]     angle_high;
    logic [FRAME_ID_W-1:0] frame_id;
  } in_item_t;

  typedef struct packed {
    logic [2:0]                    pad;
    logic signed [DIST_OUT_W-1:0]  total_distance_um;
    logic signed [Q10_W-1:0]       total_angle_q10;
    logic signed [TURN_OUT_W-1:0]  turn_count;
    logic [TEMP_W-1:0]             temperature;
    logic signed [WORD_W-1:0]      current_raw;
    logic signed [WORD_W-1:0]      speed_rpm;
    logic [ANGLE_W-1:0]            angle_counts;
    logic [MOTOR_IDX_W-1:0]        motor_index;
  } out_item_t;

  // one state memory entry per motor
  typedef struct packed {
    logic [ANGLE_W-1:0]          angle;
    logic signed [TURN_BITS-1:0] turns;
  } entry_t;

  localparam int ENTRY_W = ANGLE_W + TURN_BITS;

  // updated frame handed from the tracker to the scaler
  typedef struct packed {
    logic [SLOT_W-1:0]           slot;
    logic [ANGLE_W-1:0]          angle;
    logic [WORD_W-1:0]           speed;
    logic [WORD_W-1:0]           current;
    logic [TEMP_W-1:0]           temp;
    logic signed [TURN_BITS-1:0] turns;
  } feed_t;

endpackage

>>> hw/rtl/mfmd_ram.sv
module mfmd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/mfmd_track.sv
`include "motor_feedback_multiturn_decode_defines.svh"

module mfmd_track (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  mfmd_pkg::in_item_t                  in_item,
  input  logic [mfmd_pkg::FRAME_ID_W-1:0]     base_id,
  output logic                                feed_valid,
  input  logic                                feed_ready,
  output mfmd_pkg::feed_t                     feed
);

  logic [mfmd_pkg::FRAME_ID_W-1:0] id_diff;
  logic                            hit;
  logic [mfmd_pkg::SLOT_W-1:0]     slot_in;
  logic                            en1;
  logic                            en2;

  logic                            s1_valid_r;
  logic                            s1_valid_nxt;
  logic [mfmd_pkg::SLOT_W-1:0]     s1_slot_r;
  logic [mfmd_pkg::ANGLE_W-1:0]    s1_angle_r;
  logic [mfmd_pkg::WORD_W-1:0]     s1_speed_r;
  logic [mfmd_pkg::WORD_W-1:0]     s1_current_r;
  logic [mfmd_pkg::TEMP_W-1:0]     s1_temp_r;

  logic                            s2_valid_r;
  logic                            s2_valid_nxt;
  mfmd_pkg::feed_t                 s2_feed_r;

  logic [mfmd_pkg::SLOT_W-1:0]     rd_addr;
  logic [mfmd_pkg::ENTRY_W-1:0]    rd_data;
  logic                            wr_en;
  mfmd_pkg::entry_t                wr_data;

  logic                            fwd_valid_r;
  logic [mfmd_pkg::SLOT_W-1:0]     fwd_slot_r;
  mfmd_pkg::entry_t                fwd_data_r;
  logic                            fwd_hit;

  logic [mfmd_pkg::MOTOR_COUNT-1:0] entry_valid_r;
  logic [mfmd_pkg::MOTOR_COUNT-1:0] entry_valid_nxt;

  mfmd_pkg::entry_t                      cur;
  logic signed [mfmd_pkg::JUMP_W-1:0]    jump;
  logic signed [mfmd_pkg::TURN_BITS-1:0] turns_cur;
  logic signed [mfmd_pkg::TURN_BITS-1:0] turns_new;

  // decode the identifier
  always_comb begin
    id_diff = in_item.frame_id - base_id;
    hit     = (in_item.frame_id >= base_id) &&
              (id_diff < mfmd_pkg::FRAME_ID_W'(mfmd_pkg::MOTOR_COUNT));
    slot_in = id_diff[mfmd_pkg::SLOT_W-1:0];
  end

  assign en2      = !s2_valid_r || feed_ready;
  assign en1      = !s1_valid_r || en2;
  assign in_ready = en1;

  assign s1_valid_nxt = en1 ? (in_valid && hit) : s1_valid_r;
  assign s2_valid_nxt = en2 ? s1_valid_r : s2_valid_r;

  // re-read the held slot while stage one stalls
  assign rd_addr = en1 ? slot_in : s1_slot_r;
  assign wr_en   = s1_valid_r && en2;

  mfmd_ram #(
    .WIDTH (mfmd_pkg::ENTRY_W),
    .DEPTH (mfmd_pkg::MOTOR_COUNT),
    .AW    (mfmd_pkg::SLOT_W)
  ) u_state_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (s1_slot_r),
    .wdata (wr_data),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // a write in the read cycle is not seen by the RAM output: bypass it
  assign fwd_hit = fwd_valid_r && (fwd_slot_r == s1_slot_r);

  always_comb begin
    if (fwd_hit) begin
      cur = fwd_data_r;
    end else if (entry_valid_r[s1_slot_r]) begin
      cur = mfmd_pkg::entry_t'(rd_data);
    end else begin
      cur = '0;
    end
    turns_cur = cur.turns;
    jump      = $signed({1'b0, s1_angle_r}) - $signed({1'b0, cur.angle});
    turns_new = turns_cur;
    if (jump > mfmd_pkg::HALF_TURN) begin
      if (turns_cur != mfmd_pkg::TURN_MIN) begin
        turns_new = turns_cur - 1'b1;
      end
    end else if (jump < mfmd_pkg::NEG_HALF_TURN) begin
      if (turns_cur != mfmd_pkg::TURN_MAX) begin
        turns_new = turns_cur + 1'b1;
      end
    end
    wr_data.angle = s1_angle_r;
    wr_data.turns = turns_new;
  end

  always_comb begin
    entry_valid_nxt = entry_valid_r;
    if (wr_en) begin
      entry_valid_nxt[s1_slot_r] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r    <= 1'b0;
      s2_valid_r    <= 1'b0;
      fwd_valid_r   <= 1'b0;
      entry_valid_r <= '0;
    end else begin
      s1_valid_r    <= s1_valid_nxt;
      s2_valid_r    <= s2_valid_nxt;
      fwd_valid_r   <= wr_en;
      entry_valid_r <= entry_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_slot_r    <= slot_in;
      s1_angle_r   <= {in_item.angle_high, in_item.angle_low};
      s1_speed_r   <= {in_item.speed_high, in_item.speed_low};
      s1_current_r <= {in_item.current_high, in_item.current_low};
      s1_temp_r    <= in_item.temperature_byte;
    end
    if (en2) begin
      s2_feed_r.slot    <= s1_slot_r;
      s2_feed_r.angle   <= s1_angle_r;
      s2_feed_r.speed   <= s1_speed_r;
      s2_feed_r.current <= s1_current_r;
      s2_feed_r.temp    <= s1_temp_r;
      s2_feed_r.turns   <= turns_new;
    end
    fwd_slot_r <= s1_slot_r;
    fwd_data_r <= wr_data;
  end

  assign feed_valid = s2_valid_r;
  assign feed       = s2_feed_r;

  `MFMD_ASSERT_RST(a_rst_clears, (!rst_n) |=> (!s1_valid_r && !s2_valid_r && !fwd_valid_r), "pipeline not empty after reset")
  `MFMD_ASSERT(a_s1_hold, (s1_valid_r && !en2) |=> (s1_valid_r && $stable(s1_slot_r) && !fwd_valid_r), "stalled frame lost its slot")
  `MFMD_ASSERT(a_turn_step, wr_en |-> ((turns_new == turns_cur) || (turns_new == turns_cur + 1'b1) || (turns_new == turns_cur - 1'b1)), "turn count moved by more than one")

endmodule

>>> hw/rtl/mfmd_scale.sv
`include "motor_feedback_multiturn_decode_defines.svh"

module mfmd_scale (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            feed_valid,
  output logic                            feed_ready,
  input  mfmd_pkg::feed_t                 feed,
  input  logic [mfmd_pkg::DIST_W-1:0]     dist_per_turn,
  output logic                            out_valid,
  input  logic                            out_ready,
  output mfmd_pkg::out_item_t             out_item
);

  logic signed [mfmd_pkg::POS_W-1:0]             pos;
  logic [mfmd_pkg::LO_W+mfmd_pkg::DIST_W-1:0]    pp_lo_nxt;
  logic signed [mfmd_pkg::HI_W+mfmd_pkg::DIST_W:0] pp_hi_nxt;
  logic signed [mfmd_pkg::Q10_EXT_W-1:0]         q10_full;

  logic                                          en3;
  logic                                          en4;
  logic                                          v3_r;
  logic                                          v3_nxt;
  mfmd_pkg::feed_t                               meta3_r;
  logic [mfmd_pkg::Q10_W-1:0]                    q10_r;
  logic [mfmd_pkg::LO_W+mfmd_pkg::DIST_W-1:0]    pp_lo_r;
  logic signed [mfmd_pkg::HI_W+mfmd_pkg::DIST_W:0] pp_hi_r;

  logic signed [mfmd_pkg::DIST_EXT_W-1:0]        dist_full;
  logic                                          v4_r;
  logic                                          v4_nxt;
  mfmd_pkg::out_item_t                           out_item_r;
  mfmd_pkg::out_item_t                           out_item_nxt;

  // position in counts, Q10 angle, two distance partial products
  always_comb begin
    pos = (mfmd_pkg::POS_W'($signed(feed.turns)) <<< mfmd_pkg::FRAC_BITS) +
          mfmd_pkg::POS_W'(feed.angle);
    pp_lo_nxt = (mfmd_pkg::LO_W + mfmd_pkg::DIST_W)'(pos[mfmd_pkg::LO_W-1:0]) *
                (mfmd_pkg::LO_W + mfmd_pkg::DIST_W)'(dist_per_turn);
    pp_hi_nxt = $signed(pos[mfmd_pkg::POS_W-1:mfmd_pkg::LO_W]) *
                $signed({1'b0, dist_per_turn});
    q10_full  = mfmd_pkg::Q10_EXT_W'(pos) *
                mfmd_pkg::Q10_EXT_W'(mfmd_pkg::Q10_PER_COUNT);
  end

  assign en4        = !v4_r || out_ready;
  assign en3        = !v3_r || en4;
  assign feed_ready = en3;
  assign v3_nxt     = en3 ? feed_valid : v3_r;
  assign v4_nxt     = en4 ? v3_r : v4_r;

  // recombine partial products; keep bits above the 13-bit fraction
  always_comb begin
    dist_full = (mfmd_pkg::DIST_EXT_W'(pp_hi_r) <<< mfmd_pkg::LO_W) +
                mfmd_pkg::DIST_EXT_W'(pp_lo_r);
    out_item_nxt.pad               = '0;
    out_item_nxt.total_distance_um =
      dist_full[mfmd_pkg::FRAC_BITS+mfmd_pkg::DIST_OUT_W-1:mfmd_pkg::FRAC_BITS];
    out_item_nxt.total_angle_q10   = q10_r;
    out_item_nxt.turn_count        = mfmd_pkg::TURN_OUT_W'(meta3_r.turns);
    out_item_nxt.temperature       = meta3_r.temp;
    out_item_nxt.current_raw       = meta3_r.current;
    out_item_nxt.speed_rpm         = meta3_r.speed;
    out_item_nxt.angle_counts      = meta3_r.angle;
    out_item_nxt.motor_index       = mfmd_pkg::MOTOR_IDX_W'(meta3_r.slot);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v3_r <= v3_nxt;
      v4_r <= v4_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      meta3_r <= feed;
      q10_r   <= q10_full[mfmd_pkg::Q10_W-1:0];
      pp_lo_r <= pp_lo_nxt;
      pp_hi_r <= pp_hi_nxt;
    end
    if (en4) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = v4_r;
  assign out_item  = out_item_r;

  `MFMD_ASSERT(a_s3_hold, (v3_r && !en4) |=> (v3_r && $stable(q10_r) && $stable(pp_lo_r)), "stalled product changed")
  `MFMD_ASSERT(a_s3_load, (feed_valid && feed_ready) |=> v3_r, "taken frame did not reach the product stage")
  `MFMD_ASSERT(a_s4_load, (v3_r && en4) |=> out_valid, "product stage did not reach the output")

endmodule

>>> hw/rtl/motor_feedback_multiturn_decode.sv
// Channel  | Dir | Handshake          | Payload
// in_      | in  | in_tvalid/tready   | in_tdata: CAN frame id and payload bytes 0..6
// out_     | out | out_tvalid/tready  | out_tdata: decoded motor feedback
// cfg_     | in  | cfg_valid/ready    | cfg_index, cfg_data: register write
//
// One frame per cycle unless out_tready stalls; frames pass stages s1, s2, v3, v4.
// The per-motor state memory is read on accept and written back as the frame
// leaves stage one, with a bypass for back-to-back frames to the same motor.
// Frames for other identifiers are taken and dropped without a result.
// Reset clears the pipeline and the entry valid bits; no clearing pass.
// Stalls on out_tready fill the stage bubbles first, then hold in_tready low.
module motor_feedback_multiturn_decode (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // frame_id[10:0], angle_high, angle_low, speed_high, speed_low,
  // current_high, current_low, temperature_byte, zero fill
  input  logic [mfmd_pkg::IN_TDATA_W-1:0]      in_tdata,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // motor_index[1:0], angle_counts, speed_rpm, current_raw, temperature,
  // turn_count, total_angle_q10, total_distance_um, zero fill
  output logic [mfmd_pkg::OUT_TDATA_W-1:0]     out_tdata,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [mfmd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mfmd_pkg::CFG_DATA_W-1:0]      cfg_data
);

  logic [mfmd_pkg::FRAME_ID_W-1:0] base_id_r;
  logic [mfmd_pkg::DIST_W-1:0]     dist_per_turn_r;

  mfmd_pkg::in_item_t  in_item;
  mfmd_pkg::out_item_t out_item;
  mfmd_pkg::feed_t     feed;
  logic                feed_valid;
  logic                feed_ready;

  assign cfg_ready = 1'b1;
  assign in_item   = mfmd_pkg::in_item_t'(in_tdata);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_id_r       <= mfmd_pkg::BASE_ID_RESET;
      dist_per_turn_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        mfmd_pkg::REG_BASE_FRAME_ID: begin
          base_id_r <= cfg_data[mfmd_pkg::FRAME_ID_W-1:0];
        end
        mfmd_pkg::REG_DIST_PER_TURN: begin
          dist_per_turn_r <= cfg_data[mfmd_pkg::DIST_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  mfmd_track u_track (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_item    (in_item),
    .base_id    (base_id_r),
    .feed_valid (feed_valid),
    .feed_ready (feed_ready),
    .feed       (feed)
  );

  mfmd_scale u_scale (
    .clk           (clk),
    .rst_n         (rst_n),
    .feed_valid    (feed_valid),
    .feed_ready    (feed_ready),
    .feed          (feed),
    .dist_per_turn (dist_per_turn_r),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .out_item      (out_item)
  );

  assign out_tdata = out_item;

endmodule
